// File: hdl/weighted_concordance_correlation_assert.svh
// Assertion macros shared by the checker of the concordance correlation block
`ifndef WEIGHTED_CONCORDANCE_CORRELATION_ASSERT_SVH
`define WEIGHTED_CONCORDANCE_CORRELATION_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define WCC_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define WCC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/wcc_pkg.sv
// Package: widths, codes and control structs of the concordance correlation block
package wcc_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned WEIGHT_W  = 8;
  localparam int unsigned CCC_W     = 32;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 8;

  // Accumulator widths
  localparam int unsigned WSUM_W  = 24;
  localparam int unsigned SUM_W   = 40;
  localparam int unsigned SQ_W    = 56;
  localparam int unsigned COUNT_W = 17;

  // Item limit per data set
  localparam logic [COUNT_W-1:0] MAX_ITEMS = 17'd65536;

  // Finishing arithmetic width and iterative unit sizes
  localparam int unsigned ACC_W      = 144;
  localparam int unsigned DIGIT_W    = 8;
  localparam int unsigned MUL_STEPS  = ACC_W / DIGIT_W;
  localparam int unsigned MUL_CNT_W  = $clog2(MUL_STEPS);
  localparam int unsigned FRAC_W     = 30;
  localparam int unsigned DIV_STEPS  = 32;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int unsigned STEP_W     = 4;
  localparam logic [STEP_W-1:0] LAST_STEP = 4'd9;

  typedef logic signed [ACC_W-1:0] wide_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_CORRECTION = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_USE_WEIGHTS     = 8'd1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_WT  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO_DEN = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

  // Multiplier operand selects
  typedef enum logic [2:0] {
    OPA_S, OPA_A, OPA_P, OPA_D, OPA_F1, OPA_F2
  } opa_e;

  typedef enum logic [3:0] {
    OPB_AA, OPB_PP, OPB_X, OPB_A, OPB_P, OPB_D, OPB_VAVP, OPB_DD, OPB_CV2
  } opb_e;

  // Temporary register written by a product
  typedef enum logic [2:0] {
    DST_VA, DST_VP, DST_CV, DST_DD, DST_DEN, DST_NUM
  } dest_e;

  typedef enum logic [1:0] {
    WR_LOAD, WR_ADD, WR_SUB
  } wmode_e;

  // Controller to datapath
  typedef struct packed {
    logic                item_load;
    logic                item_square;
    logic                item_acc;
    logic                acc_clear;
    logic                mul_start;
    opa_e                opa;
    opb_e                opb;
    logic                wr_en;
    dest_e               dest;
    wmode_e              wmode;
    logic                div_abs;
    logic                div_init;
    logic                div_step;
    logic                out_load;
    logic [STATUS_W-1:0] status;
  } wcc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last;
    logic count_ovf;
    logic wsum_zero;
    logic den_bad;
    logic mul_done;
    logic out_busy;
  } wcc_stat_t;

endpackage

// File: hdl/wcc_if.sv
// Handshake channel interfaces: input items, result items and register writes
interface wcc_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [wcc_pkg::SAMPLE_W-1:0]  actual_value;
  logic signed [wcc_pkg::SAMPLE_W-1:0]  predicted_value;
  logic        [wcc_pkg::WEIGHT_W-1:0]  weight;
  logic                                 last_item;

  modport source (output valid, actual_value, predicted_value, weight, last_item,
                  input ready);
  modport sink   (input valid, actual_value, predicted_value, weight, last_item,
                  output ready);
endinterface

interface wcc_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [wcc_pkg::CCC_W-1:0]    corr_value;
  logic        [wcc_pkg::STATUS_W-1:0] status;

  modport source (output valid, corr_value, status, input ready);
  modport sink   (input valid, corr_value, status, output ready);
endinterface

interface wcc_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [wcc_pkg::CFG_IDX_W-1:0]        reg_index;
  logic [wcc_pkg::CFG_DAT_W-1:0]        wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

// File: hdl/wcc_mul.sv
// Iterative wide multiplier: one 8-bit digit of the second operand per cycle
module wcc_mul (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  wcc_pkg::wide_t a_i,
  input  wcc_pkg::wide_t b_i,
  output wcc_pkg::wide_t prod_o,
  output logic           done_o
);

  logic [wcc_pkg::ACC_W-1:0]     a_sh_q, b_q, acc_q;
  logic                          neg_q;
  logic [wcc_pkg::MUL_CNT_W-1:0] cnt_q;
  logic                          busy_q, fin_q, done_q;
  wcc_pkg::wide_t                prod_q;
  logic [wcc_pkg::ACC_W+wcc_pkg::DIGIT_W-1:0] pp;

  // partial product of the shifted multiplicand and the current digit
  assign pp = a_sh_q * b_q[wcc_pkg::DIGIT_W-1:0];

  // control of the digit loop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == wcc_pkg::MUL_CNT_W'(wcc_pkg::MUL_STEPS - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  // operand magnitudes, sum of partial products, signed result
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_sh_q <= a_i[wcc_pkg::ACC_W-1] ? -a_i : a_i;
      b_q    <= b_i[wcc_pkg::ACC_W-1] ? -b_i : b_i;
      neg_q  <= a_i[wcc_pkg::ACC_W-1] ^ b_i[wcc_pkg::ACC_W-1];
      acc_q  <= '0;
    end else if (busy_q) begin
      acc_q  <= acc_q + pp[wcc_pkg::ACC_W-1:0];
      a_sh_q <= a_sh_q << wcc_pkg::DIGIT_W;
      b_q    <= b_q >> wcc_pkg::DIGIT_W;
    end
    if (fin_q) begin
      prod_q <= neg_q ? -acc_q : acc_q;
    end
  end

  assign prod_o = prod_q;
  assign done_o = done_q;

endmodule

// File: hdl/wcc_dp.sv
// Datapath: accumulators, moment registers, multiplier, divider and result register
module wcc_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [wcc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [wcc_pkg::CFG_DAT_W-1:0]   cfg_data_i,
  input  logic signed [wcc_pkg::SAMPLE_W-1:0] actual_i,
  input  logic signed [wcc_pkg::SAMPLE_W-1:0] predicted_i,
  input  logic [wcc_pkg::WEIGHT_W-1:0]    weight_i,
  input  logic                            last_i,
  input  wcc_pkg::wcc_cmd_t               cmd_i,
  output wcc_pkg::wcc_stat_t              stat_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [wcc_pkg::CCC_W-1:0] ccc_o,
  output logic [wcc_pkg::STATUS_W-1:0]    status_o
);

  localparam int unsigned W = wcc_pkg::ACC_W;

  // configuration
  logic bias_q, use_w_q;

  // captured item and products
  logic signed [wcc_pkg::SAMPLE_W-1:0] a_q, p_q;
  logic [wcc_pkg::WEIGHT_W-1:0]        w_q;
  logic                                last_q;
  logic [31:0]                         aa_q, pp_q;
  logic signed [31:0]                  ap_q;
  logic signed [31:0]                  a_x, p_x;

  // accumulators
  logic [wcc_pkg::WSUM_W-1:0]        s_q;
  logic signed [wcc_pkg::SUM_W-1:0]  sa_q, sp_q;
  logic [wcc_pkg::SQ_W-1:0]          saa_q, spp_q;
  logic signed [wcc_pkg::SQ_W-1:0]   sx_q;
  logic [wcc_pkg::COUNT_W-1:0]       cnt_q;

  // finishing registers
  wcc_pkg::wide_t va_q, vp_q, cv_q, dd_q, den_q, num_q;
  logic [W-1:0]   rem_q, dsh_q;
  logic           neg_q;
  logic [wcc_pkg::DIV_STEPS-1:0] q_q;

  // result register
  logic                             out_valid_q;
  logic signed [wcc_pkg::CCC_W-1:0] ccc_q;
  logic [wcc_pkg::STATUS_W-1:0]     status_q;

  logic signed [24:0] wa, wp;
  logic [39:0]        waa, wpp;
  logic signed [40:0] wap;
  logic signed [wcc_pkg::SUM_W:0] diff_ap;
  wcc_pkg::wide_t op_s, op_a, op_p, op_d, op_f1, op_f2;
  wcc_pkg::wide_t mul_a, mul_b, prod, cur, wr_val;
  logic           mul_done;
  logic [W:0]     div_diff;
  logic [wcc_pkg::DIV_STEPS-1:0] q_clamp;
  logic signed [wcc_pkg::CCC_W-1:0] q_signed;

  // samples sign-extended to the product width
  assign a_x = 32'(a_q);
  assign p_x = 32'(p_q);

  // weighted terms of one item
  assign wa  = $signed({1'b0, w_q}) * a_q;
  assign wp  = $signed({1'b0, w_q}) * p_q;
  assign waa = w_q * aa_q;
  assign wpp = w_q * pp_q;
  assign wap = $signed({1'b0, w_q}) * ap_q;

  // operands of the finishing products
  assign diff_ap = {sa_q[wcc_pkg::SUM_W-1], sa_q} - {sp_q[wcc_pkg::SUM_W-1], sp_q};
  assign op_s  = {{(W-wcc_pkg::WSUM_W){1'b0}}, s_q};
  assign op_a  = {{(W-wcc_pkg::SUM_W){sa_q[wcc_pkg::SUM_W-1]}}, sa_q};
  assign op_p  = {{(W-wcc_pkg::SUM_W){sp_q[wcc_pkg::SUM_W-1]}}, sp_q};
  assign op_d  = {{(W-wcc_pkg::SUM_W-1){diff_ap[wcc_pkg::SUM_W]}}, diff_ap};
  assign op_f1 = bias_q ? op_s - W'(1) : W'(1);
  assign op_f2 = bias_q ? op_s : W'(1);

  always_comb begin
    case (cmd_i.opa)
      wcc_pkg::OPA_S:  mul_a = op_s;
      wcc_pkg::OPA_A:  mul_a = op_a;
      wcc_pkg::OPA_P:  mul_a = op_p;
      wcc_pkg::OPA_D:  mul_a = op_d;
      wcc_pkg::OPA_F1: mul_a = op_f1;
      wcc_pkg::OPA_F2: mul_a = op_f2;
      default:         mul_a = '0;
    endcase
    case (cmd_i.opb)
      wcc_pkg::OPB_AA:   mul_b = {{(W-wcc_pkg::SQ_W){1'b0}}, saa_q};
      wcc_pkg::OPB_PP:   mul_b = {{(W-wcc_pkg::SQ_W){1'b0}}, spp_q};
      wcc_pkg::OPB_X:    mul_b = {{(W-wcc_pkg::SQ_W){sx_q[wcc_pkg::SQ_W-1]}}, sx_q};
      wcc_pkg::OPB_A:    mul_b = op_a;
      wcc_pkg::OPB_P:    mul_b = op_p;
      wcc_pkg::OPB_D:    mul_b = op_d;
      wcc_pkg::OPB_VAVP: mul_b = va_q + vp_q;
      wcc_pkg::OPB_DD:   mul_b = dd_q;
      wcc_pkg::OPB_CV2:  mul_b = cv_q <<< 1;
      default:           mul_b = '0;
    endcase
  end

  wcc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .prod_o  (prod),
    .done_o  (mul_done)
  );

  // write-back of a product into its temporary
  always_comb begin
    case (cmd_i.dest)
      wcc_pkg::DST_VA:  cur = va_q;
      wcc_pkg::DST_VP:  cur = vp_q;
      wcc_pkg::DST_CV:  cur = cv_q;
      wcc_pkg::DST_DD:  cur = dd_q;
      wcc_pkg::DST_DEN: cur = den_q;
      wcc_pkg::DST_NUM: cur = num_q;
      default:          cur = '0;
    endcase
    case (cmd_i.wmode)
      wcc_pkg::WR_ADD: wr_val = cur + prod;
      wcc_pkg::WR_SUB: wr_val = cur - prod;
      default:         wr_val = prod;
    endcase
  end

  // restoring division step and final clamp of the quotient to one
  assign div_diff = {1'b0, rem_q} - {1'b0, dsh_q};
  assign q_clamp  = (q_q > wcc_pkg::DIV_STEPS'(1 << wcc_pkg::FRAC_W))
                    ? wcc_pkg::DIV_STEPS'(1 << wcc_pkg::FRAC_W) : q_q;
  assign q_signed = neg_q ? -$signed(q_clamp) : $signed(q_clamp);

  // control registers: configuration, count, accumulators, result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q      <= 1'b0;
      use_w_q     <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      s_q         <= '0;
      sa_q        <= '0;
      sp_q        <= '0;
      saa_q       <= '0;
      spp_q       <= '0;
      sx_q        <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == wcc_pkg::REG_BIAS_CORRECTION) begin
        bias_q <= cfg_data_i[0];
      end
      if (cfg_we_i && cfg_idx_i == wcc_pkg::REG_USE_WEIGHTS) begin
        use_w_q <= cfg_data_i[0];
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.acc_clear) begin
        cnt_q <= '0;
        s_q   <= '0;
        sa_q  <= '0;
        sp_q  <= '0;
        saa_q <= '0;
        spp_q <= '0;
        sx_q  <= '0;
      end else if (cmd_i.item_acc) begin
        if (cnt_q < wcc_pkg::MAX_ITEMS) begin
          cnt_q <= cnt_q + 1'b1;
          s_q   <= s_q + wcc_pkg::WSUM_W'(w_q);
          sa_q  <= sa_q + {{(wcc_pkg::SUM_W-25){wa[24]}}, wa};
          sp_q  <= sp_q + {{(wcc_pkg::SUM_W-25){wp[24]}}, wp};
          saa_q <= saa_q + {{(wcc_pkg::SQ_W-40){1'b0}}, waa};
          spp_q <= spp_q + {{(wcc_pkg::SQ_W-40){1'b0}}, wpp};
          sx_q  <= sx_q + {{(wcc_pkg::SQ_W-41){wap[40]}}, wap};
        end else begin
          cnt_q <= wcc_pkg::MAX_ITEMS + 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      a_q    <= actual_i;
      p_q    <= predicted_i;
      w_q    <= use_w_q ? weight_i : wcc_pkg::WEIGHT_W'(1);
      last_q <= last_i;
    end
    if (cmd_i.item_square) begin
      aa_q <= a_x * a_x;
      pp_q <= p_x * p_x;
      ap_q <= a_x * p_x;
    end
    if (cmd_i.wr_en) begin
      case (cmd_i.dest)
        wcc_pkg::DST_VA:  va_q  <= wr_val;
        wcc_pkg::DST_VP:  vp_q  <= wr_val;
        wcc_pkg::DST_CV:  cv_q  <= wr_val;
        wcc_pkg::DST_DD:  dd_q  <= wr_val;
        wcc_pkg::DST_DEN: den_q <= wr_val;
        wcc_pkg::DST_NUM: num_q <= wr_val;
        default: ;
      endcase
    end
    if (cmd_i.div_abs) begin
      rem_q <= num_q[W-1] ? -num_q : num_q;
      neg_q <= num_q[W-1];
    end
    // scaled magnitude plus half the divisor for round to nearest
    if (cmd_i.div_init) begin
      rem_q <= (rem_q << wcc_pkg::FRAC_W) + (den_q >> 1);
      dsh_q <= den_q << (wcc_pkg::DIV_STEPS - 1);
      q_q   <= '0;
    end
    if (cmd_i.div_step) begin
      if (!div_diff[W]) begin
        rem_q <= div_diff[W-1:0];
      end
      q_q   <= {q_q[wcc_pkg::DIV_STEPS-2:0], ~div_diff[W]};
      dsh_q <= dsh_q >> 1;
    end
    if (cmd_i.out_load) begin
      status_q <= cmd_i.status;
      ccc_q    <= (cmd_i.status == wcc_pkg::ST_OK) ? q_signed : '0;
    end
  end

  assign stat_o.last      = last_q;
  assign stat_o.count_ovf = cnt_q > wcc_pkg::MAX_ITEMS;
  assign stat_o.wsum_zero = s_q == '0;
  assign stat_o.den_bad   = den_q[W-1] || den_q == '0;
  assign stat_o.mul_done  = mul_done;
  assign stat_o.out_busy  = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign ccc_o       = ccc_q;
  assign status_o    = status_q;

endmodule

// File: hdl/wcc_ctrl.sv
// Controller: sequences accumulation, the finishing products, division and result hand-off
module wcc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  wcc_pkg::wcc_stat_t stat_i,
  output wcc_pkg::wcc_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_SQUARE, S_ACC, S_CHECK, S_MUL_GO, S_MUL_WAIT,
    S_CHK_DEN, S_DIV_ABS, S_DIV_INIT, S_DIV_RUN, S_DONE
  } state_e;

  state_e                         state_q;
  logic [wcc_pkg::STEP_W-1:0]     step_q;
  logic [wcc_pkg::DIV_CNT_W-1:0]  div_cnt_q;
  logic [wcc_pkg::STATUS_W-1:0]   status_q;

  // state, step counters and result status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      step_q    <= '0;
      div_cnt_q <= '0;
      status_q  <= wcc_pkg::ST_OK;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_SQUARE;
        end
        S_SQUARE: state_q <= S_ACC;
        S_ACC: begin
          state_q <= stat_i.last ? S_CHECK : S_IDLE;
        end
        S_CHECK: begin
          step_q <= '0;
          if (stat_i.count_ovf) begin
            status_q <= wcc_pkg::ST_OVERFLOW;
            state_q  <= S_DONE;
          end else if (stat_i.wsum_zero) begin
            status_q <= wcc_pkg::ST_ZERO_WT;
            state_q  <= S_DONE;
          end else begin
            state_q <= S_MUL_GO;
          end
        end
        S_MUL_GO: state_q <= S_MUL_WAIT;
        S_MUL_WAIT: begin
          if (stat_i.mul_done) begin
            if (step_q == wcc_pkg::LAST_STEP) begin
              state_q <= S_CHK_DEN;
            end else begin
              step_q  <= step_q + 1'b1;
              state_q <= S_MUL_GO;
            end
          end
        end
        S_CHK_DEN: begin
          if (stat_i.den_bad) begin
            status_q <= wcc_pkg::ST_ZERO_DEN;
            state_q  <= S_DONE;
          end else begin
            state_q <= S_DIV_ABS;
          end
        end
        S_DIV_ABS: state_q <= S_DIV_INIT;
        S_DIV_INIT: begin
          div_cnt_q <= '0;
          state_q   <= S_DIV_RUN;
        end
        S_DIV_RUN: begin
          div_cnt_q <= div_cnt_q + 1'b1;
          if (div_cnt_q == wcc_pkg::DIV_CNT_W'(wcc_pkg::DIV_STEPS - 1)) begin
            status_q <= wcc_pkg::ST_OK;
            state_q  <= S_DONE;
          end
        end
        S_DONE: begin
          if (!stat_i.out_busy) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // commands decoded from the state and the product step
  always_comb begin
    cmd_o             = '0;
    cmd_o.opa         = wcc_pkg::OPA_S;
    cmd_o.opb         = wcc_pkg::OPB_AA;
    cmd_o.dest        = wcc_pkg::DST_VA;
    cmd_o.wmode       = wcc_pkg::WR_LOAD;
    cmd_o.status      = status_q;
    cmd_o.item_load   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.item_square = state_q == S_SQUARE;
    cmd_o.item_acc    = state_q == S_ACC;
    cmd_o.mul_start   = state_q == S_MUL_GO;
    cmd_o.wr_en       = (state_q == S_MUL_WAIT) && stat_i.mul_done;
    cmd_o.div_abs     = state_q == S_DIV_ABS;
    cmd_o.div_init    = state_q == S_DIV_INIT;
    cmd_o.div_step    = state_q == S_DIV_RUN;
    cmd_o.out_load    = (state_q == S_DONE) && !stat_i.out_busy;
    cmd_o.acc_clear   = cmd_o.out_load;
    // S*AA - A*A, S*PP - P*P, S*X - A*P, D*D, then denominator and numerator
    case (step_q)
      4'd0: begin
        cmd_o.opa = wcc_pkg::OPA_S;  cmd_o.opb = wcc_pkg::OPB_AA;
        cmd_o.dest = wcc_pkg::DST_VA;  cmd_o.wmode = wcc_pkg::WR_LOAD;
      end
      4'd1: begin
        cmd_o.opa = wcc_pkg::OPA_A;  cmd_o.opb = wcc_pkg::OPB_A;
        cmd_o.dest = wcc_pkg::DST_VA;  cmd_o.wmode = wcc_pkg::WR_SUB;
      end
      4'd2: begin
        cmd_o.opa = wcc_pkg::OPA_S;  cmd_o.opb = wcc_pkg::OPB_PP;
        cmd_o.dest = wcc_pkg::DST_VP;  cmd_o.wmode = wcc_pkg::WR_LOAD;
      end
      4'd3: begin
        cmd_o.opa = wcc_pkg::OPA_P;  cmd_o.opb = wcc_pkg::OPB_P;
        cmd_o.dest = wcc_pkg::DST_VP;  cmd_o.wmode = wcc_pkg::WR_SUB;
      end
      4'd4: begin
        cmd_o.opa = wcc_pkg::OPA_S;  cmd_o.opb = wcc_pkg::OPB_X;
        cmd_o.dest = wcc_pkg::DST_CV;  cmd_o.wmode = wcc_pkg::WR_LOAD;
      end
      4'd5: begin
        cmd_o.opa = wcc_pkg::OPA_A;  cmd_o.opb = wcc_pkg::OPB_P;
        cmd_o.dest = wcc_pkg::DST_CV;  cmd_o.wmode = wcc_pkg::WR_SUB;
      end
      4'd6: begin
        cmd_o.opa = wcc_pkg::OPA_D;  cmd_o.opb = wcc_pkg::OPB_D;
        cmd_o.dest = wcc_pkg::DST_DD;  cmd_o.wmode = wcc_pkg::WR_LOAD;
      end
      4'd7: begin
        cmd_o.opa = wcc_pkg::OPA_F1; cmd_o.opb = wcc_pkg::OPB_VAVP;
        cmd_o.dest = wcc_pkg::DST_DEN; cmd_o.wmode = wcc_pkg::WR_LOAD;
      end
      4'd8: begin
        cmd_o.opa = wcc_pkg::OPA_F2; cmd_o.opb = wcc_pkg::OPB_DD;
        cmd_o.dest = wcc_pkg::DST_DEN; cmd_o.wmode = wcc_pkg::WR_ADD;
      end
      4'd9: begin
        cmd_o.opa = wcc_pkg::OPA_F1; cmd_o.opb = wcc_pkg::OPB_CV2;
        cmd_o.dest = wcc_pkg::DST_NUM; cmd_o.wmode = wcc_pkg::WR_LOAD;
      end
      default: ;
    endcase
  end

  assign in_ready_o = state_q == S_IDLE;

endmodule

// File: hdl/weighted_concordance_correlation.sv
// Top level of the weighted concordance correlation coefficient block
// Each input item passes through capture, squares and weighted accumulate before the
// next item is accepted. An item marked last then starts the finishing sequence:
// ten wide products through one iterative multiplier that handles an 8-bit digit
// per cycle, then a 32-step restoring divider; overflow and zero weight results skip
// the products, and a zero denominator result skips the divider.
// The result waits in an output register; accumulators clear as it is loaded there.
// Registers can be written whenever the block holds no unfinished item.
module weighted_concordance_correlation (
  input  logic      clk_i,
  input  logic      rst_ni,
  wcc_cfg_if.sink   cfg_i,
  wcc_in_if.sink    in_i,
  wcc_out_if.source out_o
);

  wcc_pkg::wcc_cmd_t  cmd;
  wcc_pkg::wcc_stat_t stat;

  // register writes are always taken
  assign cfg_i.ready = 1'b1;

  wcc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  wcc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_i.valid),
    .cfg_idx_i   (cfg_i.reg_index),
    .cfg_data_i  (cfg_i.wr_data),
    .actual_i    (in_i.actual_value),
    .predicted_i (in_i.predicted_value),
    .weight_i    (in_i.weight),
    .last_i      (in_i.last_item),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .ccc_o       (out_o.corr_value),
    .status_o    (out_o.status)
  );

endmodule

// File: hdl/wcc_checker.sv
// Port checker of the concordance correlation block, bound to the top level
`include "weighted_concordance_correlation_assert.svh"

module wcc_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic signed [wcc_pkg::CCC_W-1:0]      corr_value,
  input logic        [wcc_pkg::STATUS_W-1:0]   status
);

  // stalled result holds
  `WCC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(corr_value) && $stable(status), "result changed while stalled")
  // error results carry a zero coefficient
  `WCC_ASSERT_NOW(a_err_zero, out_valid && status != wcc_pkg::ST_OK, corr_value == '0, "error result with nonzero value")
  // coefficient within minus one to one
  `WCC_ASSERT_NOW(a_range, out_valid, corr_value <= 32'sd1073741824 && corr_value >= -32'sd1073741824, "coefficient out of range")
  // no result appears right after an item is taken
  `WCC_ASSERT_NEXT(a_no_rush, in_valid && in_ready, !$rose(out_valid), "result too soon after an item")

endmodule

bind weighted_concordance_correlation wcc_checker u_wcc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (in_i.valid),
  .in_ready   (in_i.ready),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .corr_value (out_o.corr_value),
  .status     (out_o.status)
);

// File: tb/tb.sv
// Self-checking testbench of the weighted concordance correlation block
`timescale 1ns / 100ps

module tb;

  typedef logic signed [255:0] big_t;
  typedef struct packed {
    logic signed [wcc_pkg::CCC_W-1:0] ccc;
    logic [wcc_pkg::STATUS_W-1:0]     st;
  } ccc_res_t;

  localparam int unsigned WDOG_LIMIT = 5000;
  localparam int unsigned DRAIN_CYC  = 400;
  localparam longint      Q30_ONE    = 64'd1073741824;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  wcc_cfg_if cfg_if ();
  wcc_in_if  in_if ();
  wcc_out_if out_if ();

  weighted_concordance_correlation dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if.sink),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  always #10 clk_i = ~clk_i;

  // Model state
  logic   m_bias, m_usew;
  longint m_wsum, m_sa, m_sp, m_saa, m_spp, m_sx;
  int     m_cnt;
  ccc_res_t expected_ccc[$];
  int     errors = 0;
  int     idle_pct = 0;
  int     stall_pct = 0;
  int     quiet_cyc = 0;

  function automatic void clear_sums();
    m_wsum = 0; m_sa = 0; m_sp = 0; m_saa = 0; m_spp = 0; m_sx = 0; m_cnt = 0;
  endfunction

  // Final coefficient from the exact sums, rounded to Q2.30
  function automatic ccc_res_t ccc_of_sums();
    ccc_res_t r;
    big_t s, a, p, va, vp, cv, d, dd, num, den, mag, q, k;
    logic neg;
    r.ccc = '0;
    if (m_cnt > int'(wcc_pkg::MAX_ITEMS)) begin
      r.st = wcc_pkg::ST_OVERFLOW;
      return r;
    end
    if (m_wsum == 0) begin
      r.st = wcc_pkg::ST_ZERO_WT;
      return r;
    end
    s = m_wsum; a = m_sa; p = m_sp;
    va = s * big_t'(m_saa) - a * a;
    vp = s * big_t'(m_spp) - p * p;
    cv = s * big_t'(m_sx) - a * p;
    d = a - p;
    dd = d * d;
    if (m_bias) begin
      k = m_wsum - 1;
      num = 2 * k * cv;
      den = k * (va + vp) + s * dd;
    end else begin
      num = 2 * cv;
      den = va + vp + dd;
    end
    if (den <= 0) begin
      r.st = wcc_pkg::ST_ZERO_DEN;
      return r;
    end
    neg = num < 0;
    mag = neg ? -num : num;
    mag = (mag <<< 30) + (den >>> 1);
    q = mag / den;
    if (q > Q30_ONE) q = Q30_ONE;
    r.ccc = neg ? -q[31:0] : q[31:0];
    r.st = wcc_pkg::ST_OK;
    return r;
  endfunction

  // Update the sums with one accepted item
  function automatic void accumulate_pair(logic signed [15:0] av, logic signed [15:0] pv,
                                          logic [7:0] wt, logic lst);
    longint a, p, w;
    a = av; p = pv;
    w = m_usew ? longint'(wt) : 1;
    if (m_cnt < int'(wcc_pkg::MAX_ITEMS)) begin
      m_cnt++;
      m_wsum += w; m_sa += w * a; m_sp += w * p;
      m_saa += w * (a * a); m_spp += w * (p * p); m_sx += w * (a * p);
    end else begin
      m_cnt = int'(wcc_pkg::MAX_ITEMS) + 1;
    end
    if (lst) begin
      expected_ccc.push_back(ccc_of_sums());
      clear_sums();
    end
  endfunction

  // Send one item; called just after a falling edge
  task automatic send_pair(logic signed [15:0] av, logic signed [15:0] pv,
                           logic [7:0] wt, logic lst);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.actual_value = av;
    in_if.predicted_value = pv;
    in_if.weight = wt;
    in_if.last_item = lst;
    do @(posedge clk_i); while (!in_if.ready);
    accumulate_pair(av, pv, wt, lst);
    @(negedge clk_i);
    in_if.valid = 1'b0;
  endtask

  // Register writes, only once the block has gone quiet
  task automatic set_cfg(logic bias, logic usew);
    logic [wcc_pkg::CFG_IDX_W-1:0] idx;
    logic d;
    wait (expected_ccc.size() == 0);
    repeat (DRAIN_CYC) @(negedge clk_i);
    for (int i = 0; i < 2; i++) begin
      idx = (i == 0) ? wcc_pkg::REG_BIAS_CORRECTION : wcc_pkg::REG_USE_WEIGHTS;
      d = (i == 0) ? bias : usew;
      cfg_if.valid = 1'b1;
      cfg_if.reg_index = idx;
      cfg_if.wr_data = {7'd0, d};
      do @(posedge clk_i); while (!cfg_if.ready);
      if (idx == wcc_pkg::REG_BIAS_CORRECTION) m_bias = d;
      else m_usew = d;
      @(negedge clk_i);
      cfg_if.valid = 1'b0;
    end
  endtask

  // Directed sets: extremes, zero weight sum and zero denominator
  task automatic test_directed();
    set_cfg(1'b0, 1'b1);
    // zero weight sum
    send_pair(16'sd100, -16'sd5, 8'd0, 1'b0);
    send_pair(16'sd7, 16'sd9, 8'd0, 1'b1);
    // extremes, mostly at full weight
    send_pair(16'sh7fff, 16'sh7fff, 8'd255, 1'b0);
    send_pair(16'sh8000, 16'sh8000, 8'd255, 1'b0);
    send_pair(16'sh8000, 16'sh7fff, 8'd1, 1'b1);
    // anti-correlated extremes
    send_pair(16'sh7fff, 16'sh8000, 8'd255, 1'b0);
    send_pair(16'sh8000, 16'sh7fff, 8'd255, 1'b1);
    // all samples equal: zero denominator
    send_pair(16'sd42, 16'sd42, 8'd3, 1'b0);
    send_pair(16'sd42, 16'sd42, 8'd9, 1'b1);
    set_cfg(1'b1, 1'b0);
    // single item with correction: zero or nonzero mean difference
    send_pair(16'sd5, 16'sd5, 8'd0, 1'b1);
    send_pair(16'sd5, -16'sd5, 8'd0, 1'b1);
    send_pair(16'sd1, 16'sd2, 8'hff, 1'b0);
    send_pair(16'sd3, 16'sd4, 8'h00, 1'b0);
    send_pair(-16'sd1, 16'sd0, 8'haa, 1'b1);
    set_cfg(1'b1, 1'b1);
    send_pair(16'sd10, 16'sd11, 8'd1, 1'b0);
    send_pair(16'sd20, 16'sd19, 8'd128, 1'b0);
    send_pair(-16'sd30, -16'sd31, 8'd255, 1'b1);
    send_pair(16'sd0, 16'sd0, 8'd0, 1'b1);
  endtask

  // Random data sets of random shape and content
  task automatic test_random(int n_items);
    int sent, len, mode, pick;
    logic signed [15:0] av, pv, base;
    logic [7:0] wt;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(7) == 0) set_cfg(1'($urandom_range(1)), 1'($urandom_range(1)));
      pick = $urandom_range(99);
      len = (pick < 70) ? $urandom_range(16, 1) :
            (pick < 90) ? $urandom_range(64, 17) : $urandom_range(3, 1);
      mode = $urandom_range(4);
      base = 16'($urandom);
      for (int i = 0; i < len; i++) begin
        case (mode)
          0: begin
            av = 16'($urandom); pv = 16'($urandom);
          end
          1: begin
            av = 16'($urandom); pv = av + $signed(16'($urandom_range(64))) - 16'sd32;
          end
          2: begin
            av = base; pv = ($urandom_range(1) != 0) ? base : base + 16'sd1;
          end
          3: begin
            av = $signed(16'($urandom_range(20))) - 16'sd10;
            pv = -av + $signed(16'($urandom_range(4))) - 16'sd2;
          end
          default: begin
            av = ($urandom_range(1) != 0) ? 16'sh7fff : 16'sh8000;
            pv = ($urandom_range(1) != 0) ? 16'sh7fff : 16'sh8000;
          end
        endcase
        wt = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom);
        send_pair(av, pv, wt, i == len - 1);
        sent++;
      end
    end
  endtask

  // Receiver stalls
  always @(negedge clk_i)
    out_if.ready <= ($urandom_range(99) >= stall_pct);

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_ccc.size() == 0) begin
        $display("%0t: unexpected result ccc=%0d status=%0d", $time,
                 out_if.corr_value, out_if.status);
        errors++;
      end else begin
        if (out_if.corr_value !== expected_ccc[0].ccc) begin
          $display("%0t: corr_value expected %0d actual %0d", $time,
                   expected_ccc[0].ccc, out_if.corr_value);
          errors++;
        end
        if (out_if.status !== expected_ccc[0].st) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   expected_ccc[0].st, out_if.status);
          errors++;
        end
        void'(expected_ccc.pop_front());
      end
    end
  end

  // Watchdog on cycles with no handshake
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      quiet_cyc <= 0;
    else
      quiet_cyc <= quiet_cyc + 1;
    if (quiet_cyc > WDOG_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.actual_value = '0;
    in_if.predicted_value = '0;
    in_if.weight = '0;
    in_if.last_item = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.reg_index = '0;
    cfg_if.wr_data = '0;
    out_if.ready = 1'b0;
    m_bias = 1'b0;
    m_usew = 1'b0;
    clear_sums();
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    idle_pct = 36; stall_pct = 72;
    test_random(480);
    idle_pct = 72; stall_pct = 36;
    test_random(480);
    idle_pct = 0; stall_pct = 0;
    test_random(490);

    wait (expected_ccc.size() == 0);
    repeat (DRAIN_CYC) @(negedge clk_i);
    if (errors == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule
